>>> design/kpad_pkg.sv
// kpad_pkg: shared widths, request codes, repeat modes and thresholds
// for the keypad edge latch with auto-repeat. No dependencies.
package kpad_pkg;

    localparam int KEY_W        = 7;
    localparam int MAX_KEYS     = 7;
    localparam int DEF_NUM_KEYS = 7;
    localparam int MODE_W       = 3;
    localparam int COUNT_W      = 12;
    localparam int CFG_IDX_W    = 3;

    typedef enum logic [1:0] {
        REQ_SAMPLE    = 2'd0,
        REQ_TICK      = 2'd1,
        REQ_READ_DOWN = 2'd2,
        REQ_READ_UP   = 2'd3
    } req_t;

    localparam logic [MODE_W-1:0] MODE_STOP        = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SLOW        = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MEDIUM_SLOW = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MEDIUM      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MEDIUM_FAST = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FAST        = 3'd5;

    function automatic logic [COUNT_W-1:0] mode_limit(input logic [MODE_W-1:0] mode);
        logic [COUNT_W-1:0] lim;
        unique case (mode)
            MODE_SLOW:        lim = 12'd4000;
            MODE_MEDIUM_SLOW: lim = 12'd2000;
            MODE_MEDIUM:      lim = 12'd500;
            MODE_MEDIUM_FAST: lim = 12'd250;
            MODE_FAST:        lim = 12'd75;
            default:          lim = 12'd0;
        endcase
        return lim;
    endfunction

endpackage

>>> design/keypad_edge_latch_autorepeat.sv
// keypad_edge_latch_autorepeat: edge latches, held/released masks, per-key repeat counters.
// Depends on kpad_pkg.
//
// channel | signals                                  | dir | handshake
// --------+------------------------------------------+-----+--------------------
// in      | req_type, pin_levels                     | in  | in_valid / in_ready
// out     | key_mask                                 | out | out_valid / out_ready
// cfg     | cfg_index, cfg_data                      | in  | cfg_valid / cfg_ready
//
// One item per cycle while in_ready is high: each request updates the key state and
// repeat counters in the cycle it is accepted; its result is registered.
// A two-entry output buffer (result register plus skid) keeps intake going while
// a result waits; in_ready drops only when both entries are full.
// cfg_ready is always high; writes take effect at the next edge.
// Reset clears all latches, masks, counters and repeat modes.
module keypad_edge_latch_autorepeat
    import kpad_pkg::*;
#(
    parameter int NUM_KEYS = DEF_NUM_KEYS
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           req_type,
    input  logic [KEY_W-1:0]     pin_levels,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [KEY_W-1:0]     key_mask,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MODE_W-1:0]    cfg_data
);

    localparam int ACT_KEYS = (NUM_KEYS < MAX_KEYS) ? NUM_KEYS : MAX_KEYS;

    logic [MODE_W-1:0]   mode_reg  [ACT_KEYS];
    logic [COUNT_W-1:0]  count_reg [ACT_KEYS];
    logic [COUNT_W-1:0]  count_next[ACT_KEYS];

    logic [ACT_KEYS-1:0] prev_reg, prev_next;
    logic [ACT_KEYS-1:0] down_reg, down_next;
    logic [ACT_KEYS-1:0] up_reg,   up_next;
    logic [ACT_KEYS-1:0] held_reg, held_next;
    logic [ACT_KEYS-1:0] rel_reg,  rel_next;
    logic [ACT_KEYS-1:0] pressed;
    logic [KEY_W-1:0]    result;

    logic                out_valid_reg, skid_valid_reg;
    logic [KEY_W-1:0]    out_data_reg, skid_data_reg;

    logic accept, out_fire;
    req_t req;

    assign req       = req_t'(req_type);
    assign in_ready  = !skid_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign key_mask  = out_data_reg;
    assign cfg_ready = 1'b1;
    assign pressed   = ~pin_levels[ACT_KEYS-1:0];

    always_comb
    begin
        prev_next = prev_reg;
        down_next = down_reg;
        up_next   = up_reg;
        held_next = held_reg;
        rel_next  = rel_reg;
        result    = '0;
        for (int k = 0; k < ACT_KEYS; k++)
        begin
            count_next[k] = count_reg[k];
        end
        unique case (req)
            REQ_SAMPLE:
            begin
                down_next = down_reg | (pressed & ~prev_reg);
                up_next   = up_reg | (~pressed & prev_reg);
                prev_next = pressed;
                held_next = (held_reg | down_next) & ~up_next;
                rel_next  = rel_reg | up_next;
            end
            REQ_TICK:
            begin
                for (int k = 0; k < ACT_KEYS; k++)
                begin
                    if (mode_reg[k] != MODE_STOP && held_reg[k])
                    begin
                        if (rel_reg[k])
                        begin
                            count_next[k] = '0;
                        end
                        else if (count_reg[k] >= mode_limit(mode_reg[k]))
                        begin
                            down_next[k]  = 1'b1;
                            count_next[k] = '0;
                        end
                        else
                        begin
                            count_next[k] = count_reg[k] + COUNT_W'(1);
                        end
                    end
                end
                rel_next = '0;
            end
            REQ_READ_DOWN:
            begin
                result    = KEY_W'(down_reg);
                down_next = '0;
            end
            REQ_READ_UP:
            begin
                result  = KEY_W'(up_reg);
                up_next = '0;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    // key state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            down_reg <= '0;
            up_reg   <= '0;
            held_reg <= '0;
            rel_reg  <= '0;
            for (int k = 0; k < ACT_KEYS; k++)
            begin
                count_reg[k] <= '0;
            end
        end
        else if (accept)
        begin
            prev_reg <= prev_next;
            down_reg <= down_next;
            up_reg   <= up_next;
            held_reg <= held_next;
            rel_reg  <= rel_next;
            for (int k = 0; k < ACT_KEYS; k++)
            begin
                count_reg[k] <= count_next[k];
            end
        end
    end

    // repeat modes; out-of-range index or mode is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ACT_KEYS; k++)
            begin
                mode_reg[k] <= MODE_STOP;
            end
        end
        else if (cfg_valid && cfg_data <= MODE_FAST)
        begin
            for (int k = 0; k < ACT_KEYS; k++)
            begin
                if (cfg_index == CFG_IDX_W'(k))
                begin
                    mode_reg[k] <= cfg_data;
                end
            end
        end
    end

    // result register plus skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_data_reg <= result;
            end
            else
            begin
                skid_data_reg <= result;
            end
        end
    end

endmodule

>>> design/kpad_chk.sv
// kpad_chk: port-level checks for keypad_edge_latch_autorepeat, bound to the top level.
// Depends on kpad_pkg.
module kpad_chk
    import kpad_pkg::*;
#(
    parameter int NUM_KEYS = DEF_NUM_KEYS
)(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [KEY_W-1:0]     key_mask
);

    localparam int ACT_KEYS = (NUM_KEYS < MAX_KEYS) ? NUM_KEYS : MAX_KEYS;
    localparam logic [KEY_W-1:0] KEY_BITS = KEY_W'((1 << ACT_KEYS) - 1);

    // a waiting result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(key_mask))
        else $error("result changed while stalled");

    // intake stops only behind a pending result
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("in_ready low with no result pending");

    // every accepted item leaves a result behind
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted item produced no result");

    // bits of absent keys never show
    a_absent_keys: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (key_mask & ~KEY_BITS) == '0)
        else $error("key_mask has bits beyond the key count");

endmodule

bind keypad_edge_latch_autorepeat kpad_chk #(.NUM_KEYS(NUM_KEYS)) u_kpad_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .key_mask  (key_mask)
);
